// ===== src/assert_macros.svh =====
// assertion macros shared by the checker files
// clock is clk, synchronous active-low reset is rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BOE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define BOE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/boe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boe_pkg
// Types, character codes and the byte classifier shared by the escaper.
// ----------------------------------------------------------------------------
package boe_pkg;

  // most bytes that one input item can expand into
  localparam int RUN_MAX = 4;
  localparam int IDX_W   = $clog2(RUN_MAX);

  // run descriptor queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'o177;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  // index of the last byte of a run, per run kind
  localparam logic [IDX_W-1:0] LAST_PLAIN = IDX_W'(0);
  localparam logic [IDX_W-1:0] LAST_PAIR  = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_OCTAL = IDX_W'(3);

  // one escaped run, bytes in output order starting at index 0
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [IDX_W-1:0]        last_idx;
    logic                    done;
  } run_t;

  // turn one source byte into its escaped run
  function automatic run_t classify(input logic [7:0] b, input logic done);
    run_t r;
    r.done     = done;
    r.bytes    = {RUN_MAX{CH_BSLASH}};
    r.last_idx = LAST_PAIR;
    priority if (b == CH_BSLASH) begin
      r.bytes[1] = CH_BSLASH;
    end else if (b == CH_LF) begin
      r.bytes[1] = CH_N;
    end else if (b == CH_CR) begin
      r.bytes[1] = CH_R;
    end else if (b == CH_TAB) begin
      r.bytes[1] = CH_T;
    end else if (b < CH_SPACE || b >= CH_DEL) begin
      r.bytes[1] = CH_ZERO + {6'b0, b[7:6]};
      r.bytes[2] = CH_ZERO + {5'b0, b[5:3]};
      r.bytes[3] = CH_ZERO + {5'b0, b[2:0]};
      r.last_idx = LAST_OCTAL;
    end else begin
      r.bytes[0] = b;
      r.last_idx = LAST_PLAIN;
    end
    return r;
  endfunction

endpackage

// ===== src/boe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boe_front
// Input side: takes source bytes and classifies each into a run descriptor.
// ----------------------------------------------------------------------------
module boe_front import boe_pkg::*; (
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  input  logic       q_full,
  output logic       q_push,
  output run_t       q_data
);

  // accept whenever the descriptor queue has room
  assign full   = q_full;
  assign q_push = push && !q_full;

  // classify the byte into its escaped run
  assign q_data = classify(in_byte, in_end_of_text);

endmodule

// ===== src/boe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boe_queue
// Short FIFO of run descriptors between front and back.
// ----------------------------------------------------------------------------
module boe_queue import boe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  run_t wr_data,
  output logic full,
  input  logic rd_en,
  output run_t rd_data,
  output logic empty
);

  run_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_wr, do_rd;

  assign full    = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/boe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boe_back
// Output side: walks the current run and presents one escaped byte per item.
// ----------------------------------------------------------------------------
module boe_back import boe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  run_t       q_data,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_done
);

  logic             cur_valid_r, cur_valid_nxt;
  run_t             cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             at_last;
  logic             advance;
  logic             load;

  assign at_last = (idx_r == cur_r.last_idx);
  assign advance = cur_valid_r && pop;
  assign load    = !q_empty && (!cur_valid_r || (advance && at_last));
  assign q_pop   = load;

  // result ports come straight from the run register
  assign empty         = !cur_valid_r;
  assign out_byte      = cur_r.bytes[idx_r];
  assign out_run_last  = at_last;
  assign out_text_done = at_last && cur_r.done;

  // step through the run, refill from the queue at its end
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_data;
      idx_nxt       = '0;
    end else if (advance) begin
      if (at_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // run payload, no reset needed
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

// ===== src/backslash_octal_escaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backslash_octal_escaper
// C-style string escaper: one source byte in, a run of 1, 2 or 4 bytes out.
// ----------------------------------------------------------------------------
// Each source byte pushed in comes out as its escaped run, one byte per popped
// item: plain bytes pass as one byte, backslash, newline, carriage return and
// tab as two, other control bytes and bytes from 0x7F up as a backslash and
// three octal digits. out_run_last marks the last byte of each run and
// out_text_done that byte for the string's final source byte. The output side
// delivers one byte per cycle while pop is held and runs are waiting; a
// two-entry descriptor queue lets new items be pushed while a run is still
// draining. When the block is idle, an accepted item is written into the queue
// and then loaded into the run register, from which its first byte is shown.
module backslash_octal_escaper import boe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_done
);

  logic q_full;
  logic q_push;
  run_t q_wr_data;
  logic q_pop;
  run_t q_rd_data;
  logic q_empty;

  // classify incoming bytes
  boe_front u_front (
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wr_data)
  );

  // decouple classification from serialization
  boe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // emit escaped bytes
  boe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rd_data),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_done (out_text_done)
  );

endmodule

// ===== src/boe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boe_checker
// Port-level assertions for the escaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module boe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_text_done
);

  // nothing waits to be taken and there is room right after reset
  `BOE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (empty && !full), "not idle after reset")

  // string end only ever falls on the last byte of a run
  `BOE_ASSERT(a_done_on_last, (!empty && out_text_done) |-> out_run_last, "text_done off run end")

  // a run never breaks off in the middle
  `BOE_ASSERT(a_run_continues, (!empty && pop && !out_run_last) |=> !empty, "run cut short")

  // a waiting item holds until taken
  `BOE_ASSERT(a_hold_stalled, (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_run_last) && $stable(out_text_done)), "stalled item changed")

endmodule

bind backslash_octal_escaper boe_checker u_boe_checker (.*);

// ===== tb/sv/escape_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_checker
// Watches both sides of the escaper, predicts every escaped byte and
// compares each popped byte against the oldest expected one.
// ----------------------------------------------------------------------------
module escape_checker import boe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       out_run_last,
  input  logic       out_text_done,
  output int         errors,
  output int         pending,
  output int         bytes_checked
);

  // cap on printed mismatch lines, the count keeps going
  localparam int SHOW_MAX = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_done;
  } esc_byte_t;

  esc_byte_t escaped_bytes[$];

  initial begin
    errors        = 0;
    pending       = 0;
    bytes_checked = 0;
  end

  // expand one source byte into its escaped run
  task automatic predict_escape(input logic [7:0] b, input logic eot);
    logic [7:0] run [4];
    int         n;
    run[0] = CH_BSLASH;
    run[1] = 8'h00;
    run[2] = 8'h00;
    run[3] = 8'h00;
    if (b == CH_BSLASH) begin
      run[1] = CH_BSLASH;
      n = 2;
    end else if (b == CH_LF) begin
      run[1] = CH_N;
      n = 2;
    end else if (b == CH_CR) begin
      run[1] = CH_R;
      n = 2;
    end else if (b == CH_TAB) begin
      run[1] = CH_T;
      n = 2;
    end else if (b < CH_SPACE || b >= CH_DEL) begin
      // three octal digits, most significant first
      run[1] = CH_ZERO + {6'd0, b[7:6]};
      run[2] = CH_ZERO + {5'd0, b[5:3]};
      run[3] = CH_ZERO + {5'd0, b[2:0]};
      n = 4;
    end else begin
      run[0] = b;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      escaped_bytes.push_back('{run[k], k == n - 1, (k == n - 1) && eot});
    end
  endtask

  task automatic report(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
    errors++;
    if (errors <= SHOW_MAX) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    end
  endtask

  // output side first, then the item taken in at the same edge
  always @(posedge clk) begin
    esc_byte_t exp_b;
    if (rst_n) begin
      if (pop && !empty) begin
        if (escaped_bytes.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, out_byte);
          end
        end else begin
          exp_b = escaped_bytes.pop_front();
          bytes_checked++;
          if (out_byte !== exp_b.data) report("out_byte", exp_b.data, out_byte);
          if (out_run_last !== exp_b.run_last) begin
            report("out_run_last", {7'd0, exp_b.run_last}, {7'd0, out_run_last});
          end
          if (out_text_done !== exp_b.text_done) begin
            report("out_text_done", {7'd0, exp_b.text_done}, {7'd0, out_text_done});
          end
        end
      end
      if (push && !full) predict_escape(in_byte, in_end_of_text);
      pending = escaped_bytes.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the backslash octal escaper.
// ----------------------------------------------------------------------------
// Pushes directed bytes (range ends, every escape class, the zero byte), then
// random strings with random gaps on the push side and random pop stalls,
// with a stretch free of gaps. A separate checker predicts and compares.
module testbench;

  localparam int RANDOM_ITEMS = 80;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 12;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_end_of_text;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_done;

  int errors;
  int pending;
  int bytes_checked;
  int items_sent;
  int idle_cycles;
  int pop_hold;
  int str_len;
  int strings_sent;
  bit calm;
  bit pop_run;

  backslash_octal_escaper dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .in_end_of_text(in_end_of_text),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_done (out_text_done)
  );

  escape_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .in_end_of_text(in_end_of_text),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_done (out_text_done),
    .errors        (errors),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long, none in a calm stretch
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // source byte weighted toward the escape classes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 8'h5C;
        1: return 8'h0A;
        2: return 8'h0D;
        default: return 8'h09;
      endcase
    end
    if (r < 65) return 8'($urandom_range(1, 8'h1F));
    if (r < 85) return 8'($urandom_range(8'h7F, 8'hFF));
    return 8'($urandom_range(1, 255));
  endfunction

  // push one item after a random gap, junk on the data while idle
  task automatic send_item(input logic [7:0] b, input logic eot);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push           <= 1'b0;
      in_byte        <= 8'($urandom);
      in_end_of_text <= 1'($urandom);
    end
    @(negedge clk);
    push           <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // pop side with random stalls
  always @(negedge clk) begin
    if (!pop_run) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 2) == 0) pop_hold = pick_gap();
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d bytes outstanding", idle_cycles, pending);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] directed [16];
    bit         broken;
    push           = 1'b0;
    pop            = 1'b0;
    in_byte        = 8'h00;
    in_end_of_text = 1'b0;
    rst_n          = 1'b0;
    items_sent     = 0;
    idle_cycles    = 0;
    pop_hold       = 0;
    strings_sent   = 0;
    calm           = 1'b0;
    pop_run        = 1'b0;
    directed = '{8'h01, 8'hFF, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h00, 8'h1F,
                 8'h20, 8'h7E, 8'h7F, 8'h80, 8'h41, 8'hAA, 8'h55, 8'h5C};

    // synchronous reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    pop_run <= 1'b1;

    // directed items, end flag on every third one
    for (int i = 0; i < 16; i++) send_item(directed[i], (i % 3) == 2);
    send_item(8'h7F, 1'b1);
    send_item(8'h5C, 1'b1);
    send_item(8'h0A, 1'b1);
    send_item(8'hFF, 1'b1);

    // random strings, a calm stretch in the middle
    while (items_sent < 20 + RANDOM_ITEMS) begin
      calm    = (items_sent >= 55) && (items_sent < 85);
      str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      broken  = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < str_len; k++) begin
        // broken strings carry the end flag at random
        send_item(pick_byte(), broken ? 1'($urandom) : (k == str_len - 1));
      end
      strings_sent++;
    end
    calm = 1'b0;
    @(negedge clk);
    push <= 1'b0;

    // drain and let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("pushed %0d source bytes (%0d random strings), checked %0d escaped bytes",
             items_sent, strings_sent, bytes_checked);
    $display("stalls on both sides, %0d mismatches", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== backslash_octal_escaper.f =====
+incdir+src
src/boe_pkg.sv
src/boe_front.sv
src/boe_queue.sv
src/boe_back.sv
src/backslash_octal_escaper.sv
src/boe_checker.sv
tb/sv/escape_checker.sv
tb/sv/testbench.sv
